### rtl/gsp_pkg.sv
package gsp_pkg;

    typedef struct packed {
        logic        operation;
        logic [12:0] sample_mv;
    } t_in;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [12:0] average_mv;
        logic [23:0] resistance_ratio;
        logic [31:0] reference_ohms;
        logic [12:0] co2_ppm;
        logic [9:0]  co_ppm;
        logic [8:0]  nh3_ppm;
        logic [9:0]  lpg_ppm;
    } t_out;

    localparam logic [1:0] KIND_READING  = 2'd0;
    localparam logic [1:0] KIND_CAL_DONE = 2'd1;
    localparam logic [1:0] KIND_CAL_FAIL = 2'd2;

    localparam logic [2:0] REG_SUPPLY_MV   = 3'd0;
    localparam logic [2:0] REG_LOAD_OHMS   = 3'd1;
    localparam logic [2:0] REG_CLEAN_RATIO = 3'd2;
    localparam logic [2:0] REG_READ_SAMPS  = 3'd3;
    localparam logic [2:0] REG_CAL_SAMPS   = 3'd4;

    localparam logic [12:0] RST_SUPPLY_MV   = 13'd5000;
    localparam logic [19:0] RST_LOAD_OHMS   = 20'd10000;
    localparam logic [15:0] RST_CLEAN_RATIO = 16'd14746;
    localparam logic [7:0]  RST_READ_SAMPS  = 8'd10;
    localparam logic [7:0]  RST_CAL_SAMPS   = 8'd50;

    localparam logic [12:0] LOW_MV_LIMIT = 13'd10;
    localparam logic [23:0] RATIO_MAX    = 24'hFFFFFF;

    // log2 of the Q4.12 clean-air ratio carries a 12-bit fraction offset
    localparam logic signed [23:0] LC_OFS = 24'sd786432;

    // gas order: CO2, CO, NH3, LPG
    localparam logic signed [23:0] GAS_LOGB [4] = '{24'sd0, 24'sd151842, 24'sd179224,
                                                    24'sd104125};
    localparam logic [18:0] GAS_EMAG [4] = '{19'd181469, 19'd286040, 19'd159215, 19'd216870};
    localparam logic [19:0] GAS_LOGK [4] = '{20'd566484, 20'd0, 20'd0, 20'd0};
    localparam logic [12:0] GAS_HI   [4] = '{13'd5000, 13'd1000, 13'd300, 13'd1000};

    // 2^(2^-k) in Q.16
    localparam logic [16:0] EXP2_TAB [12] = '{
        17'd92682, 17'd77936, 17'd71468, 17'd68438, 17'd66971, 17'd66250,
        17'd65892, 17'd65714, 17'd65625, 17'd65580, 17'd65558, 17'd65547
    };

    localparam logic signed [47:0] Y_HI  = 48'sh0E_0000_0000;
    localparam logic signed [47:0] Y_LO  = -48'sh02_0000_0000;
    localparam logic signed [47:0] Y_OFS = 48'sh02_0000_0000;

endpackage

### rtl/gas_sensor_ppm_converter.sv
// Gas sensor ppm converter. Each request carries one load-resistor voltage
// sample (mV) and an operation bit: measurement or calibration. Samples are
// summed until the configured count for the current operation is reached
// (a change of operation restarts the sum); such requests cause no result
// and are taken with no stall. The request that completes a set starts
// the processing: average, sensor resistance Rs = (supply - avg) * load / avg,
// then either a new clean-air reference Ro = Rs / clean-air ratio
// (calibration), or the ratio Rs / Ro in Q(24-F).F and four power-law
// concentrations CO2, CO, NH3, LPG (measurement). All divisions run on one
// restoring divider that yields one quotient bit per cycle over
// D = 33 + max(F, 12) steps (49 for F = 16). The log2 unit normalizes one bit
// a cycle and then squares sixteen times on the shared 32x32 multiplier.
// Each gas then passes a multiply by its exponent, an offset add and a range
// check, then one table product per fraction bit on the multiplier and a final
// scale and clamp; a gas whose exponent falls outside the range ends at the check.
// The input stays stalled from the request that completes a set until its
// result is loaded into the output register, including any wait for that
// register to free up. A voltage too low or not below the supply, an Rs
// rounding to zero, a calibration with a zero clean-air ratio and a ratio
// rounding to zero each cut the processing short. A finished result waits
// in the output register while the next samples are taken. Configuration
// writes are for idle periods only.
module gas_sensor_ppm_converter #(
    parameter logic [31:0] RO_DEFAULT      = 32'd10000,
    parameter int          RATIO_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gsp_pkg::t_in       i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gsp_pkg::t_out      o_out_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);

    localparam int SH_MAX = (RATIO_FRAC_BITS > 12) ? RATIO_FRAC_BITS : 12;
    localparam int DIV_W  = 33 + SH_MAX;
    localparam int DCW    = $clog2(DIV_W + 1);
    localparam logic signed [23:0] LR_OFS = 24'(RATIO_FRAC_BITS * 65536);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_AVG_DIV  = 5'd1;
    localparam logic [4:0] S_RS_SETUP = 5'd2;
    localparam logic [4:0] S_RS_DIV   = 5'd3;
    localparam logic [4:0] S_RS_END   = 5'd4;
    localparam logic [4:0] S_BRANCH   = 5'd5;
    localparam logic [4:0] S_RO_DIV   = 5'd6;
    localparam logic [4:0] S_RO_END   = 5'd7;
    localparam logic [4:0] S_RAT_DIV  = 5'd8;
    localparam logic [4:0] S_RAT_END  = 5'd9;
    localparam logic [4:0] S_NORM     = 5'd10;
    localparam logic [4:0] S_SQ       = 5'd11;
    localparam logic [4:0] S_LOG_END  = 5'd12;
    localparam logic [4:0] S_DE       = 5'd13;
    localparam logic [4:0] S_YADD     = 5'd14;
    localparam logic [4:0] S_EXPCHK   = 5'd15;
    localparam logic [4:0] S_EXP      = 5'd16;
    localparam logic [4:0] S_FIN      = 5'd17;
    localparam logic [4:0] S_DONE     = 5'd18;

    // configuration
    logic [12:0] r_supply;
    logic [19:0] r_load;
    logic [15:0] r_clean;
    logic [7:0]  r_read_samps;
    logic [7:0]  r_cal_samps;

    // accumulation state and stored reference
    logic [20:0] r_sum;
    logic [7:0]  r_count;
    logic        r_mode;
    logic [31:0] r_ro;

    logic [4:0]  r_state;

    // divider
    logic [DIV_W-1:0] r_dq;
    logic [31:0]      r_drem;
    logic [31:0]      r_dden;
    logic [DCW-1:0]   r_dcnt;

    // item results
    logic [12:0] r_avg;
    logic        r_rs_inf;
    logic [31:0] r_rs;
    logic [1:0]  r_kind;
    logic [23:0] r_ratio;
    logic [12:0] r_ppm [4];

    // log2 unit
    logic [31:0] r_lm;
    logic [4:0]  r_lp;
    logic [15:0] r_lfrac;
    logic [3:0]  r_lk;
    logic        r_log_sel;
    logic signed [23:0] r_lr;
    logic signed [23:0] r_lc;

    // power evaluation
    logic [1:0]         r_gas;
    logic signed [47:0] r_y;
    logic [4:0]         r_ip;
    logic [11:0]        r_f;
    logic [17:0]        r_mant;
    logic [3:0]         r_ek;

    logic        r_out_valid;
    gsp_pkg::t_out r_out;

    // ---------------- combinational helpers ----------------
    logic        w_in_acc;
    logic [20:0] w_sum_new;
    logic [7:0]  w_count_new;
    logic [7:0]  w_target;
    logic [12:0] w_avg;

    assign w_in_acc = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        w_sum_new   = (i_in_data.operation != r_mode) ? 21'd0 : r_sum;
        w_count_new = (i_in_data.operation != r_mode) ? 8'd0 : r_count;
        w_sum_new   = w_sum_new + 21'(i_in_data.sample_mv);
        w_count_new = w_count_new + 8'd1;
        w_target    = i_in_data.operation ? r_cal_samps : r_read_samps;
        if (w_target == 8'd0) begin
            w_target = 8'd1;
        end
    end

    assign w_avg = r_dq[12:0];

    // one restoring step: shift in the next dividend bit, subtract if it fits
    logic [32:0]      w_rem_sh;
    logic             w_ge;
    logic [31:0]      w_drem_next;
    logic [DIV_W-1:0] w_dq_next;

    assign w_rem_sh    = {r_drem, r_dq[DIV_W-1]};
    assign w_ge        = w_rem_sh >= {1'b0, r_dden};
    assign w_drem_next = w_ge ? 32'(w_rem_sh - {1'b0, r_dden}) : w_rem_sh[31:0];
    assign w_dq_next   = {r_dq[DIV_W-2:0], w_ge};

    logic w_q_ov32;
    logic w_q_ov24;
    assign w_q_ov32 = |r_dq[DIV_W-1:32];
    assign w_q_ov24 = |r_dq[DIV_W-1:24];

    // gas operands
    logic signed [23:0] w_d;
    logic [23:0]        w_dmag;
    assign w_d    = (r_gas == 2'd0) ? (r_lr - r_lc) : (r_lr - gsp_pkg::GAS_LOGB[r_gas]);
    assign w_dmag = w_d[23] ? 24'(-w_d) : 24'(w_d);

    // shared multiplier
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;

    always_comb begin
        w_mul_a = 32'd0;
        w_mul_b = 32'd0;
        unique case (r_state)
            S_RS_SETUP: begin
                w_mul_a = 32'(r_supply - w_avg);
                w_mul_b = 32'(r_load);
            end
            S_SQ: begin
                w_mul_a = r_lm;
                w_mul_b = r_lm;
            end
            S_DE: begin
                w_mul_a = 32'(w_dmag);
                w_mul_b = 32'(gsp_pkg::GAS_EMAG[r_gas]);
            end
            S_EXP: begin
                w_mul_a = 32'(r_mant);
                w_mul_b = 32'(gsp_pkg::EXP2_TAB[r_ek]);
            end
            default: begin
                w_mul_a = 32'd0;
                w_mul_b = 32'd0;
            end
        endcase
    end

    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    // squaring step of the log2 unit
    logic [31:0] w_sq;
    assign w_sq = w_prod[61:30];

    logic signed [23:0] w_log;
    assign w_log = signed'(24'({r_lp, r_lfrac}));

    // exponent split
    logic [47:0] w_u;
    logic [16:0] w_y12;
    assign w_u   = 48'(r_y + gsp_pkg::Y_OFS) + 48'd524288;
    assign w_y12 = w_u[36:20];

    // final scale and clamp
    logic [33:0] w_vsh;
    logic [16:0] w_v;
    logic [12:0] w_ppm;

    always_comb begin
        if (r_ip >= 5'd2) begin
            w_vsh = (34'(r_mant) << (r_ip - 5'd2)) + 34'd32768;
            w_v   = 17'(w_vsh >> 16);
        end else if (r_ip == 5'd1) begin
            w_vsh = 34'(r_mant) + 34'd65536;
            w_v   = 17'(w_vsh >> 17);
        end else begin
            w_vsh = 34'(r_mant) + 34'd131072;
            w_v   = 17'(w_vsh >> 18);
        end
        w_ppm = (w_v > 17'(gsp_pkg::GAS_HI[r_gas])) ? gsp_pkg::GAS_HI[r_gas] : w_v[12:0];
    end

    logic w_out_free;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_supply     <= gsp_pkg::RST_SUPPLY_MV;
            r_load       <= gsp_pkg::RST_LOAD_OHMS;
            r_clean      <= gsp_pkg::RST_CLEAN_RATIO;
            r_read_samps <= gsp_pkg::RST_READ_SAMPS;
            r_cal_samps  <= gsp_pkg::RST_CAL_SAMPS;
            r_sum        <= 21'd0;
            r_count      <= 8'd0;
            r_mode       <= 1'b0;
            r_ro         <= RO_DEFAULT;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gsp_pkg::REG_SUPPLY_MV:   r_supply     <= i_cfg_data[12:0];
                    gsp_pkg::REG_LOAD_OHMS:   r_load       <= i_cfg_data;
                    gsp_pkg::REG_CLEAN_RATIO: r_clean      <= i_cfg_data[15:0];
                    gsp_pkg::REG_READ_SAMPS:  r_read_samps <= i_cfg_data[7:0];
                    gsp_pkg::REG_CAL_SAMPS:   r_cal_samps  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // load a finished result, or drop the held one once it is taken
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_mode <= i_in_data.operation;
                        if (w_count_new >= w_target) begin
                            // set complete: clear the sum, divide it by the count
                            r_sum   <= 21'd0;
                            r_count <= 8'd0;
                            r_dq    <= DIV_W'(w_sum_new);
                            r_drem  <= 32'd0;
                            r_dden  <= 32'(w_count_new);
                            r_dcnt  <= DCW'(DIV_W);
                            r_state <= S_AVG_DIV;
                        end else begin
                            r_sum   <= w_sum_new;
                            r_count <= w_count_new;
                        end
                    end
                end

                S_AVG_DIV, S_RS_DIV, S_RO_DIV, S_RAT_DIV: begin
                    r_dq   <= w_dq_next;
                    r_drem <= w_drem_next;
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) begin
                        unique case (r_state)
                            S_AVG_DIV: r_state <= S_RS_SETUP;
                            S_RS_DIV:  r_state <= S_RS_END;
                            S_RO_DIV:  r_state <= S_RO_END;
                            default:   r_state <= S_RAT_END;
                        endcase
                    end
                end

                S_RS_SETUP: begin
                    r_avg    <= w_avg;
                    r_rs_inf <= w_avg <= gsp_pkg::LOW_MV_LIMIT;
                    if (w_avg > gsp_pkg::LOW_MV_LIMIT && r_supply > w_avg) begin
                        // rounded (supply - avg) * load / avg
                        r_dq    <= DIV_W'(w_prod[32:0]) + DIV_W'(w_avg >> 1);
                        r_drem  <= 32'd0;
                        r_dden  <= 32'(w_avg);
                        r_dcnt  <= DCW'(DIV_W);
                        r_state <= S_RS_DIV;
                    end else begin
                        r_rs    <= 32'd0;
                        r_state <= S_BRANCH;
                    end
                end

                S_RS_END: begin
                    r_rs    <= w_q_ov32 ? 32'hFFFF_FFFF : r_dq[31:0];
                    r_state <= S_BRANCH;
                end

                S_BRANCH: begin
                    r_ratio <= 24'd0;
                    for (int g = 0; g < 4; g++) begin
                        r_ppm[g] <= 13'd0;
                    end
                    if (r_mode) begin
                        if (r_rs_inf || r_rs == 32'd0 || r_clean == 16'd0) begin
                            r_kind  <= gsp_pkg::KIND_CAL_FAIL;
                            r_state <= S_DONE;
                        end else begin
                            r_kind  <= gsp_pkg::KIND_CAL_DONE;
                            r_dq    <= (DIV_W'(r_rs) << 12) + DIV_W'(r_clean >> 1);
                            r_drem  <= 32'd0;
                            r_dden  <= 32'(r_clean);
                            r_dcnt  <= DCW'(DIV_W);
                            r_state <= S_RO_DIV;
                        end
                    end else begin
                        r_kind <= gsp_pkg::KIND_READING;
                        if (r_rs_inf) begin
                            r_ratio <= gsp_pkg::RATIO_MAX;
                            r_state <= S_DONE;
                        end else if (r_rs == 32'd0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_dq    <= (DIV_W'(r_rs) << RATIO_FRAC_BITS) + DIV_W'(r_ro >> 1);
                            r_drem  <= 32'd0;
                            r_dden  <= r_ro;
                            r_dcnt  <= DCW'(DIV_W);
                            r_state <= S_RAT_DIV;
                        end
                    end
                end

                S_RO_END: begin
                    if (w_q_ov32) begin
                        r_ro <= 32'hFFFF_FFFF;
                    end else if (r_dq[31:0] == 32'd0) begin
                        r_ro <= 32'd1;
                    end else begin
                        r_ro <= r_dq[31:0];
                    end
                    r_state <= S_DONE;
                end

                S_RAT_END: begin
                    if (!w_q_ov24 && r_dq[23:0] == 24'd0) begin
                        // ratio rounds to zero: every gas at its clamp, CO2 only with a nonzero clean-air ratio
                        r_ratio  <= 24'd0;
                        r_ppm[0] <= (r_clean != 16'd0) ? gsp_pkg::GAS_HI[0] : 13'd0;
                        r_ppm[1] <= gsp_pkg::GAS_HI[1];
                        r_ppm[2] <= gsp_pkg::GAS_HI[2];
                        r_ppm[3] <= gsp_pkg::GAS_HI[3];
                        r_state  <= S_DONE;
                    end else begin
                        r_ratio   <= w_q_ov24 ? gsp_pkg::RATIO_MAX : r_dq[23:0];
                        r_lm      <= w_q_ov24 ? 32'(gsp_pkg::RATIO_MAX) : 32'(r_dq[23:0]);
                        r_lp      <= 5'd30;
                        r_lfrac   <= 16'd0;
                        r_lk      <= 4'd0;
                        r_log_sel <= 1'b0;
                        r_state   <= S_NORM;
                    end
                end

                S_NORM: begin
                    // advance until the leading one sits at bit 30
                    if (r_lm[30]) begin
                        r_state <= S_SQ;
                    end else begin
                        r_lm <= {r_lm[30:0], 1'b0};
                        r_lp <= r_lp - 5'd1;
                    end
                end

                S_SQ: begin
                    r_lm    <= w_sq[31] ? {1'b0, w_sq[31:1]} : w_sq;
                    r_lfrac <= {r_lfrac[14:0], w_sq[31]};
                    r_lk    <= r_lk + 4'd1;
                    if (r_lk == 4'd15) begin
                        r_state <= S_LOG_END;
                    end
                end

                S_LOG_END: begin
                    if (!r_log_sel) begin
                        r_lr <= w_log - LR_OFS;
                        if (r_clean != 16'd0) begin
                            r_lm      <= 32'(r_clean);
                            r_lp      <= 5'd30;
                            r_lfrac   <= 16'd0;
                            r_lk      <= 4'd0;
                            r_log_sel <= 1'b1;
                            r_state   <= S_NORM;
                        end else begin
                            // no clean-air ratio: CO2 stays 0
                            r_gas   <= 2'd1;
                            r_state <= S_DE;
                        end
                    end else begin
                        r_lc    <= w_log - gsp_pkg::LC_OFS;
                        r_gas   <= 2'd0;
                        r_state <= S_DE;
                    end
                end

                S_DE: begin
                    // exponent is negative: y = -d * |e|
                    r_y <= w_d[23] ? signed'(48'(w_prod[40:0])) : -signed'(48'(w_prod[40:0]));
                    r_state <= S_YADD;
                end

                S_YADD: begin
                    r_y <= r_y + signed'(48'(gsp_pkg::GAS_LOGK[r_gas]) << 16);
                    r_state <= S_EXPCHK;
                end

                S_EXPCHK: begin
                    if (r_y >= gsp_pkg::Y_HI || r_y < gsp_pkg::Y_LO) begin
                        r_ppm[r_gas] <= (r_y >= gsp_pkg::Y_HI) ? gsp_pkg::GAS_HI[r_gas] : 13'd0;
                        if (r_gas == 2'd3) begin
                            r_state <= S_DONE;
                        end else begin
                            r_gas   <= r_gas + 2'd1;
                            r_state <= S_DE;
                        end
                    end else begin
                        r_ip    <= w_y12[16:12];
                        r_f     <= w_y12[11:0];
                        r_mant  <= 18'd65536;
                        r_ek    <= 4'd0;
                        r_state <= S_EXP;
                    end
                end

                S_EXP: begin
                    // fraction bits MSB first, one table product a cycle
                    if (r_f[11]) begin
                        r_mant <= 18'((w_prod + 64'd32768) >> 16);
                    end
                    r_f  <= {r_f[10:0], 1'b0};
                    r_ek <= r_ek + 4'd1;
                    if (r_ek == 4'd11) begin
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    r_ppm[r_gas] <= w_ppm;
                    if (r_gas == 2'd3) begin
                        r_state <= S_DONE;
                    end else begin
                        r_gas   <= r_gas + 2'd1;
                        r_state <= S_DE;
                    end
                end

                S_DONE: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out.result_kind      <= r_kind;
                        r_out.average_mv       <= r_avg;
                        r_out.resistance_ratio <= r_ratio;
                        r_out.reference_ohms   <= r_ro;
                        r_out.co2_ppm          <= r_ppm[0];
                        r_out.co_ppm           <= r_ppm[1][9:0];
                        r_out.nh3_ppm          <= r_ppm[2][8:0];
                        r_out.lpg_ppm          <= r_ppm[3][9:0];
                        r_state                <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
